### rtl/shst_pkg.sv
`default_nettype none

package shst_pkg;

    localparam int HANDLER_BITS_DEF = 16;
    localparam int TABLE_SLOTS      = 832;
    localparam int SLOT_BITS        = 10;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_GET        = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_CAN_INSERT = 3'd5,
        OP_DISPATCH   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FALSE   = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DONE
    } state_t;

    // one result item from the sequencer to the output register
    typedef struct packed {
        status_t              status;
        logic [SLOT_BITS-1:0] slot;
        logic [15:0]          handler;
        logic [4:0]           count;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

### rtl/shst_ram.sv
`default_nettype none

module shst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 832
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/shst_seq.sv
`default_nettype none

module shst_seq #(
    parameter int HANDLER_BITS = shst_pkg::HANDLER_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_vld,
    output logic                                in_rdy,
    input  wire logic [2:0]                     in_op,
    input  wire logic [7:0]                     in_code,
    input  wire logic [15:0]                    in_hid,
    input  wire logic [shst_pkg::SLOT_BITS-1:0] in_slot,
    input  wire logic                           out_free,
    output logic                                res_vld,
    output shst_pkg::res_t                      res,
    output logic                                ram_we,
    output logic [shst_pkg::SLOT_BITS-1:0]      ram_waddr,
    output logic [HANDLER_BITS-1:0]             ram_wdata,
    output logic                                ram_re,
    output logic [shst_pkg::SLOT_BITS-1:0]      ram_raddr,
    input  wire logic [HANDLER_BITS-1:0]        ram_rdata
);

    localparam int SB = shst_pkg::SLOT_BITS;

    function automatic logic [SB-1:0] code_first(input logic [7:0] c);
        if (c < 8'd16)
            return {2'b00, c[3:0], 4'h0};
        else if (c < 8'd128)
            return {c, 2'b00} + 10'd192;
        else
            return {2'b00, c} + 10'd576;
    endfunction

    function automatic logic [SB-1:0] code_last(input logic [7:0] c);
        if (c < 8'd16)
            return {2'b00, c[3:0], 4'hF};
        else if (c < 8'd128)
            return {c, 2'b11} + 10'd192;
        else
            return {2'b00, c} + 10'd576;
    endfunction

    // last slot of the block that holds slot s
    function automatic logic [SB-1:0] slot_last(input logic [SB-1:0] s);
        if (s < 10'd256)
            return {s[9:4], 4'hF};
        else if (s < 10'd704)
            return {s[9:2], 2'b11};
        else
            return s;
    endfunction

    shst_pkg::state_t state_reg, state_next;
    shst_pkg::op_t    op_reg, op_next;
    logic [HANDLER_BITS-1:0] id_reg, id_next;
    logic          iss_vld_reg, iss_vld_next;
    logic [SB-1:0] iss_addr_reg, iss_addr_next;
    logic [SB-1:0] end_addr_reg, end_addr_next;
    logic          ev_vld_reg, ev_vld_next;
    logic [SB-1:0] ev_addr_reg, ev_addr_next;
    logic          has_reg, has_next;
    logic          empty_vld_reg, empty_vld_next;
    logic [SB-1:0] empty_addr_reg, empty_addr_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [SB-1:0] pend_addr_reg, pend_addr_next;
    logic [HANDLER_BITS-1:0] pend_hid_reg, pend_hid_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          hit_reg, hit_next;
    logic          bad_reg, bad_next;
    logic          first_reg, first_next;

    // the shared compare unit
    logic d_zero;
    logic d_match;
    logic stall;
    logic stop;

    assign d_zero  = (ram_rdata == '0);
    assign d_match = (ram_rdata == id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shst_pkg::ST_WIPE;
            iss_vld_reg   <= 1'b0;
            iss_addr_reg  <= '0;
            end_addr_reg  <= shst_pkg::LAST_SLOT;
            ev_vld_reg    <= 1'b0;
            has_reg       <= 1'b0;
            empty_vld_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_vld_reg   <= iss_vld_next;
            iss_addr_reg  <= iss_addr_next;
            end_addr_reg  <= end_addr_next;
            ev_vld_reg    <= ev_vld_next;
            has_reg       <= has_next;
            empty_vld_reg <= empty_vld_next;
            pend_vld_reg  <= pend_vld_next;
            hit_reg       <= hit_next;
            bad_reg       <= bad_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        ev_addr_reg    <= ev_addr_next;
        empty_addr_reg <= empty_addr_next;
        pend_addr_reg  <= pend_addr_next;
        pend_hid_reg   <= pend_hid_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        iss_vld_next    = iss_vld_reg;
        iss_addr_next   = iss_addr_reg;
        end_addr_next   = end_addr_reg;
        ev_vld_next     = ev_vld_reg;
        ev_addr_next    = ev_addr_reg;
        has_next        = has_reg;
        empty_vld_next  = empty_vld_reg;
        empty_addr_next = empty_addr_reg;
        pend_vld_next   = pend_vld_reg;
        pend_addr_next  = pend_addr_reg;
        pend_hid_next   = pend_hid_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        bad_next        = bad_reg;
        first_next      = first_reg;

        in_rdy    = (state_reg == shst_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = iss_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = iss_addr_reg;
        res_vld   = 1'b0;
        res       = '0;
        stall     = 1'b0;
        stop      = 1'b0;

        case (state_reg)
            shst_pkg::ST_WIPE, shst_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (iss_addr_reg == end_addr_reg)
                begin
                    state_next = (state_reg == shst_pkg::ST_WIPE) ? shst_pkg::ST_IDLE
                                                                  : shst_pkg::ST_DONE;
                end
                else
                begin
                    iss_addr_next = iss_addr_reg + 10'd1;
                end
            end

            shst_pkg::ST_IDLE:
            begin
                if (in_vld)
                begin
                    op_next        = shst_pkg::op_t'(in_op);
                    id_next        = HANDLER_BITS'(in_hid);
                    has_next       = 1'b0;
                    empty_vld_next = 1'b0;
                    pend_vld_next  = 1'b0;
                    hit_next       = 1'b0;
                    bad_next       = 1'b0;
                    first_next     = 1'b1;
                    cnt_next       = '0;
                    ev_vld_next    = 1'b0;
                    iss_addr_next  = code_first(in_code);
                    end_addr_next  = code_last(in_code);
                    case (shst_pkg::op_t'(in_op))
                        shst_pkg::OP_REMOVE, shst_pkg::OP_GET:
                        begin
                            if (in_slot > shst_pkg::LAST_SLOT)
                            begin
                                bad_next   = 1'b1;
                                state_next = shst_pkg::ST_DONE;
                            end
                            else
                            begin
                                iss_addr_next = in_slot;
                                end_addr_next = (shst_pkg::op_t'(in_op) == shst_pkg::OP_GET)
                                              ? in_slot : slot_last(in_slot);
                                iss_vld_next  = 1'b1;
                                state_next    = shst_pkg::ST_SCAN;
                            end
                        end
                        shst_pkg::OP_CLEAR:
                        begin
                            state_next = shst_pkg::ST_CLEAR;
                        end
                        shst_pkg::OP_INSERT, shst_pkg::OP_CONTAINS,
                        shst_pkg::OP_CAN_INSERT, shst_pkg::OP_DISPATCH:
                        begin
                            iss_vld_next = 1'b1;
                            state_next   = shst_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = shst_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            shst_pkg::ST_SCAN:
            begin
                // dispatch holds the whole pipe while an item waits for the output
                stall = ev_vld_reg && (op_reg == shst_pkg::OP_DISPATCH) && !d_zero
                        && pend_vld_reg && !out_free;
                if (!stall)
                begin
                    ram_re       = iss_vld_reg;
                    ev_vld_next  = iss_vld_reg;
                    ev_addr_next = iss_addr_reg;
                    if (iss_vld_reg)
                    begin
                        if (iss_addr_reg == end_addr_reg)
                            iss_vld_next = 1'b0;
                        else
                            iss_addr_next = iss_addr_reg + 10'd1;
                    end
                    if (ev_vld_reg)
                    begin
                        case (op_reg)
                            shst_pkg::OP_DISPATCH:
                            begin
                                if (d_zero)
                                begin
                                    stop = 1'b1;
                                end
                                else
                                begin
                                    if (pend_vld_reg)
                                    begin
                                        res_vld     = 1'b1;
                                        res.status  = shst_pkg::STAT_OK;
                                        res.slot    = pend_addr_reg;
                                        res.handler = 16'(pend_hid_reg);
                                        res.count   = cnt_reg;
                                        res.last    = 1'b0;
                                    end
                                    pend_vld_next  = 1'b1;
                                    pend_addr_next = ev_addr_reg;
                                    pend_hid_next  = ram_rdata;
                                    cnt_next       = cnt_reg + 5'd1;
                                end
                            end
                            shst_pkg::OP_GET:
                            begin
                                hit_next      = !d_zero;
                                pend_hid_next = ram_rdata;
                                stop          = 1'b1;
                            end
                            shst_pkg::OP_REMOVE:
                            begin
                                if (first_reg)
                                begin
                                    first_next = 1'b0;
                                    if (d_zero)
                                        stop = 1'b1;
                                    else
                                        hit_next = 1'b1;
                                end
                                else
                                begin
                                    // shift down by one place
                                    ram_we    = 1'b1;
                                    ram_waddr = ev_addr_reg - 10'd1;
                                    ram_wdata = ram_rdata;
                                end
                            end
                            default:
                            begin
                                if (d_match)
                                    has_next = 1'b1;
                                if (d_zero && !empty_vld_reg)
                                begin
                                    empty_vld_next  = 1'b1;
                                    empty_addr_next = ev_addr_reg;
                                end
                            end
                        endcase
                    end
                    if (stop || !iss_vld_reg)
                    begin
                        iss_vld_next = 1'b0;
                        ev_vld_next  = 1'b0;
                        state_next   = shst_pkg::ST_DONE;
                    end
                end
            end

            shst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_vld    = 1'b1;
                    res.last   = 1'b1;
                    res.status = shst_pkg::STAT_FALSE;
                    state_next = shst_pkg::ST_IDLE;
                    case (op_reg)
                        shst_pkg::OP_INSERT:
                        begin
                            if (!has_reg && empty_vld_reg)
                            begin
                                res.status = shst_pkg::STAT_OK;
                                res.slot   = empty_addr_reg;
                                ram_we     = 1'b1;
                                ram_waddr  = empty_addr_reg;
                                ram_wdata  = id_reg;
                            end
                        end
                        shst_pkg::OP_REMOVE:
                        begin
                            if (bad_reg)
                            begin
                                res.status = shst_pkg::STAT_INVALID;
                            end
                            else if (hit_reg)
                            begin
                                res.status = shst_pkg::STAT_OK;
                                ram_we     = 1'b1;
                                ram_waddr  = end_addr_reg;
                            end
                        end
                        shst_pkg::OP_GET:
                        begin
                            if (bad_reg)
                            begin
                                res.status = shst_pkg::STAT_INVALID;
                            end
                            else if (hit_reg)
                            begin
                                res.status  = shst_pkg::STAT_OK;
                                res.handler = 16'(pend_hid_reg);
                            end
                        end
                        shst_pkg::OP_CLEAR:
                        begin
                            res.status = shst_pkg::STAT_OK;
                        end
                        shst_pkg::OP_CONTAINS:
                        begin
                            if (has_reg)
                                res.status = shst_pkg::STAT_OK;
                        end
                        shst_pkg::OP_CAN_INSERT:
                        begin
                            if (empty_vld_reg)
                                res.status = shst_pkg::STAT_OK;
                        end
                        shst_pkg::OP_DISPATCH:
                        begin
                            if (pend_vld_reg)
                            begin
                                res.status  = shst_pkg::STAT_OK;
                                res.slot    = pend_addr_reg;
                                res.handler = 16'(pend_hid_reg);
                                res.count   = cnt_reg;
                            end
                        end
                        default:
                        begin
                            res.status = shst_pkg::STAT_FALSE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = shst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/segmented_handler_slot_table.sv
`default_nettype none

// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser operation, tdata code/handler/slot
// m_*       out  m_tvalid/m_tready   tuser status, tdata slot/handler/count, tlast
//
// Insert, contains, can insert: scan the whole block, one slot a cycle through RAM and compare;
// dispatch stops at the first empty slot or at the end of a full block.
// Remove shifts the rest of the block down, or stops on an empty slot; get reads one slot;
// clear writes the whole block; invalid slot or unused operation goes straight to the result.
// After reset a clearing pass writes all 832 slots, one a cycle; s_tready low.
// A stalled output holds dispatch in place and holds the final result.

module segmented_handler_slot_table #(
    parameter int HANDLER_BITS = shst_pkg::HANDLER_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // infocode, handler_id, slot_index, zero pad
    input  wire logic [2:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // found_slot, found_handler, handler_count, zero pad
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast
);

    localparam int SB = shst_pkg::SLOT_BITS;

    logic                    out_free;
    logic                    res_vld;
    shst_pkg::res_t          res;
    logic                    ram_we;
    logic [SB-1:0]           ram_waddr;
    logic [HANDLER_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [SB-1:0]           ram_raddr;
    logic [HANDLER_BITS-1:0] ram_rdata;

    logic           out_vld_reg;
    shst_pkg::res_t out_reg;

    assign out_free = !out_vld_reg || m_tready;

    shst_seq #(
        .HANDLER_BITS(HANDLER_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (s_tvalid),
        .in_rdy    (s_tready),
        .in_op     (s_tuser),
        .in_code   (s_tdata[7:0]),
        .in_hid    (s_tdata[23:8]),
        .in_slot   (s_tdata[33:24]),
        .out_free  (out_free),
        .res_vld   (res_vld),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    shst_ram #(
        .WIDTH(HANDLER_BITS),
        .DEPTH(shst_pkg::TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg.count, out_reg.handler, out_reg.slot};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

    // an accepted item keeps the input closed in the cycle after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // failed and invalid results always close their item
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != shst_pkg::STAT_OK) |-> m_tlast)
        else $error("non-ok result without last");

    // a dispatch count only comes with a successful result
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[30:26] != 5'd0) |-> (m_tuser == shst_pkg::STAT_OK)
            && (m_tdata[30:26] <= 5'd16))
        else $error("bad dispatch count");

endmodule

`default_nettype wire

### bench/slot_table_checker.sv
`timescale 1ns / 1ps

module slot_table_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // infocode, handler_id, slot_index, zero pad
    input  wire logic [2:0]  s_tuser,   // operation
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // found_slot, found_handler, handler_count, zero pad
    input  wire logic [1:0]  m_tuser,   // status
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);
    import shst_pkg::*;

    logic [15:0] slot_ids [TABLE_SLOTS];
    res_t        awaited_results [$];
    int          errors = 0;

    function automatic void block_span(input logic [7:0] code, output int unsigned base,
                                       output int unsigned size);
        int unsigned c;
        c = int'(code);
        if (c < 16)
        begin
            base = c * 16;
            size = 16;
        end
        else if (c < 128)
        begin
            base = 16 * 16 + (c - 16) * 4;
            size = 4;
        end
        else
        begin
            base = 16 * 16 + 112 * 4 + (c - 128);
            size = 1;
        end
    endfunction

    function automatic logic [7:0] code_of_slot(input int unsigned slot);
        if (slot < 16 * 16)
            return 8'(slot / 16);
        if (slot < 16 * 16 + 112 * 4)
            return 8'((slot - 16 * 16) / 4 + 16);
        return 8'(slot - (16 * 16 + 112 * 4) + 128);
    endfunction

    function automatic void add_result(input status_t st, input int unsigned slot,
                                       input logic [15:0] handler, input int unsigned cnt,
                                       input logic lst);
        res_t r;
        r.status  = st;
        r.slot    = SLOT_BITS'(slot);
        r.handler = handler;
        r.count   = 5'(cnt);
        r.last    = lst;
        awaited_results.push_back(r);
    endfunction

    task automatic apply_operation(input logic [2:0] op, input logic [7:0] code,
                                   input logic [15:0] id, input logic [9:0] slot);
        int unsigned base, size, empty_at, k;
        bit has_id, has_empty;
        block_span(code, base, size);
        has_id    = 1'b0;
        has_empty = 1'b0;
        empty_at  = 0;
        for (int unsigned i = 0; i < size; i++)
        begin
            if (slot_ids[base + i] == id)
                has_id = 1'b1;
            if (!has_empty && slot_ids[base + i] == '0)
            begin
                has_empty = 1'b1;
                empty_at  = base + i;
            end
        end
        case (op)
            OP_INSERT:
            begin
                // id zero always collides with an empty slot
                if (!has_id && has_empty)
                begin
                    slot_ids[empty_at] = id;
                    add_result(STAT_OK, empty_at, '0, 0, 1'b1);
                end
                else
                    add_result(STAT_FALSE, 0, '0, 0, 1'b1);
            end
            OP_REMOVE:
            begin
                if (slot >= TABLE_SLOTS)
                    add_result(STAT_INVALID, 0, '0, 0, 1'b1);
                else if (slot_ids[slot] == '0)
                    add_result(STAT_FALSE, 0, '0, 0, 1'b1);
                else
                begin
                    block_span(code_of_slot(slot), base, size);
                    for (int unsigned i = slot; i + 1 < base + size; i++)
                        slot_ids[i] = slot_ids[i + 1];
                    slot_ids[base + size - 1] = '0;
                    add_result(STAT_OK, 0, '0, 0, 1'b1);
                end
            end
            OP_CLEAR:
            begin
                for (int unsigned i = 0; i < size; i++)
                    slot_ids[base + i] = '0;
                add_result(STAT_OK, 0, '0, 0, 1'b1);
            end
            OP_GET:
            begin
                if (slot >= TABLE_SLOTS)
                    add_result(STAT_INVALID, 0, '0, 0, 1'b1);
                else if (slot_ids[slot] == '0)
                    add_result(STAT_FALSE, 0, '0, 0, 1'b1);
                else
                    add_result(STAT_OK, 0, slot_ids[slot], 0, 1'b1);
            end
            OP_CONTAINS:
                add_result(has_id ? STAT_OK : STAT_FALSE, 0, '0, 0, 1'b1);
            OP_CAN_INSERT:
                add_result(has_empty ? STAT_OK : STAT_FALSE, 0, '0, 0, 1'b1);
            OP_DISPATCH:
            begin
                k = 0;
                while (k < size && slot_ids[base + k] != '0)
                begin
                    add_result(STAT_OK, base + k, slot_ids[base + k], k + 1, 1'b0);
                    k++;
                end
                if (k == 0)
                    add_result(STAT_FALSE, 0, '0, 0, 1'b1);
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
            default:
                add_result(STAT_FALSE, 0, '0, 0, 1'b1);
        endcase
    endtask

    function automatic bit field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want == got)
            return 1'b0;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    task automatic match_result();
        res_t want;
        bit   bad;
        if (awaited_results.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected: status %0d slot %0d handler %0d last %0b",
                     $time, m_tuser, m_tdata[9:0], m_tdata[25:10], m_tlast);
        end
        else
        begin
            want = awaited_results.pop_front();
            bad  = 1'b0;
            bad |= field_differs("status", want.status, m_tuser);
            bad |= field_differs("found_slot", want.slot, m_tdata[9:0]);
            bad |= field_differs("found_handler", want.handler, m_tdata[25:10]);
            bad |= field_differs("handler_count", want.count, m_tdata[30:26]);
            bad |= field_differs("last", want.last, m_tlast);
            if (bad)
                errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_ids[i])
                slot_ids[i] = '0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            // outputs first: a result never belongs to an item taken on the same edge
            if (m_tvalid && m_tready)
                match_result();
            if (s_tvalid && s_tready)
                apply_operation(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[33:24]);
            pending <= awaited_results.size();
        end
        fail_count <= errors;
    end

endmodule

### bench/segmented_handler_slot_table_tb.sv
`timescale 1ns / 1ps

module segmented_handler_slot_table_tb;
    import shst_pkg::*;

    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         PHASES       = 5;
    localparam int         PHASE_ITEMS  = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          stall_left = 0;
    int          mode_left = 0;

    segmented_handler_slot_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    slot_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver stalls: mostly short, a few long, with stall-free stretches
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            mode_left = $urandom_range(100, 400);
            stalls_on = ($urandom_range(0, 3) != 0);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_item(input logic [2:0] op, input logic [7:0] code,
                             input logic [15:0] id, input logic [9:0] slot);
        int unsigned gap, r;
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 19);
            if (r >= 17)
                gap = $urandom_range(5, 30);
            else if (r >= 10)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, slot, id, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold the sender until every awaited result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned r, base, size;
        logic [2:0]  op;
        logic [7:0]  code, slot_code;
        logic [15:0] id, id_base;
        logic [9:0]  slot;
        logic [7:0]  pool [4];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, duplicates, id zero, full blocks, invalid slots
        send_item(OP_CAN_INSERT, 8'd0, 16'd1, 10'd0);
        send_item(OP_INSERT, 8'd0, 16'hFFFF, 10'd0);
        send_item(OP_INSERT, 8'd0, 16'hFFFF, 10'd0);
        send_item(OP_INSERT, 8'd0, 16'h0000, 10'd0);
        send_item(OP_CONTAINS, 8'd0, 16'h0000, 10'd0);
        send_item(OP_CONTAINS, 8'd0, 16'hFFFF, 10'd0);
        send_item(OP_GET, 8'd0, 16'd0, 10'd0);
        send_item(OP_GET, 8'd0, 16'd0, 10'd1023);
        send_item(OP_GET, 8'd0, 16'd0, 10'd832);
        send_item(OP_GET, 8'd0, 16'd0, 10'd831);
        send_item(OP_INSERT, 8'd255, 16'd1, 10'd0);
        send_item(OP_INSERT, 8'd255, 16'd2, 10'd0);
        send_item(OP_CAN_INSERT, 8'd255, 16'd1, 10'd0);
        send_item(OP_DISPATCH, 8'd255, 16'd0, 10'd0);
        send_item(OP_DISPATCH, 8'd128, 16'd0, 10'd0);
        send_item(OP_INSERT, 8'd127, 16'hAAAA, 10'd0);
        send_item(OP_INSERT, 8'd127, 16'h5555, 10'd0);
        send_item(OP_INSERT, 8'd127, 16'd3, 10'd0);
        send_item(OP_INSERT, 8'd127, 16'd4, 10'd0);
        send_item(OP_INSERT, 8'd127, 16'd5, 10'd0);
        send_item(OP_REMOVE, 8'd0, 16'd0, 10'd700);
        send_item(OP_REMOVE, 8'd0, 16'd0, 10'd1000);
        send_item(OP_REMOVE, 8'd0, 16'd0, 10'd703);
        send_item(OP_DISPATCH, 8'd127, 16'd0, 10'd0);
        send_item(OP_CLEAR, 8'd127, 16'd0, 10'd0);
        send_item(OP_DISPATCH, 8'd127, 16'd0, 10'd0);
        send_item(OP_UNUSED, 8'd16, 16'd7, 10'd5);
        drain_results();

        // random: each phase works a few blocks hard so they fill, shift and empty
        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 2);
            pool[0] = (r == 0) ? 8'd0 : (r == 1) ? 8'd15 : 8'($urandom_range(1, 14));
            r = $urandom_range(0, 2);
            pool[1] = (r == 0) ? 8'd16 : (r == 1) ? 8'd127 : 8'($urandom_range(17, 126));
            r = $urandom_range(0, 2);
            pool[2] = (r == 0) ? 8'd128 : (r == 1) ? 8'd255 : 8'($urandom_range(129, 254));
            pool[3] = 8'($urandom_range(128, 255));
            id_base = 16'($urandom_range(1, 65000));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 34)
                    op = OP_INSERT;
                else if (r < 50)
                    op = OP_REMOVE;
                else if (r < 53)
                    op = OP_CLEAR;
                else if (r < 63)
                    op = OP_GET;
                else if (r < 73)
                    op = OP_CONTAINS;
                else if (r < 81)
                    op = OP_CAN_INSERT;
                else if (r < 98)
                    op = OP_DISPATCH;
                else
                    op = OP_UNUSED;

                r = $urandom_range(0, 99);
                if (r < 45)
                    code = pool[0];
                else if (r < 75)
                    code = pool[1];
                else if (r < 88)
                    code = pool[2];
                else if (r < 95)
                    code = pool[3];
                else
                    code = 8'($urandom_range(0, 255));

                r = $urandom_range(0, 99);
                if (r < 3)
                    id = '0;
                else if (r < 15)
                    id = 16'($urandom_range(1, 65535));
                else
                    id = id_base + 16'($urandom_range(0, 23));

                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    slot_code = pool[$urandom_range(0, 3)];
                    if (slot_code < 16)
                    begin
                        base = int'(slot_code) * 16;
                        size = 16;
                    end
                    else if (slot_code < 128)
                    begin
                        base = 16 * 16 + (int'(slot_code) - 16) * 4;
                        size = 4;
                    end
                    else
                    begin
                        base = 16 * 16 + 112 * 4 + (int'(slot_code) - 128);
                        size = 1;
                    end
                    slot = 10'(base + $urandom_range(0, size - 1));
                end
                else if (r < 92)
                    slot = 10'($urandom_range(0, TABLE_SLOTS - 1));
                else
                    slot = 10'($urandom_range(TABLE_SLOTS, 1023));

                send_item(op, code, id, slot);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS segmented_handler_slot_table");
        else
            $display("FAIL segmented_handler_slot_table");
        $finish;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL segmented_handler_slot_table");
        $finish;
    end

endmodule
